[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
// Each macro expects clock to be visible where it is used; all but ASSERT_NXT_RST also expect reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Next-cycle implication that also runs across reset.
`define ASSERT_NXT_RST(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("reset check failed");

`endif

[rtl/ispsa_pkg.sv]
`default_nettype none

package ispsa_pkg;

   localparam int DEFAULT_STACK_DEPTH = 256;

   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_SWAP = 2'd2,
      OP_ADD  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_PUSH_USAGE = 3'd1,
      ST_POP_EMPTY  = 3'd2,
      ST_SWAP_SHORT = 3'd3,
      ST_ADD_SHORT  = 3'd4,
      ST_OVERFLOW   = 3'd5
   } status_type;

   typedef struct packed {
      op_type             req_type;
      logic signed [31:0] push_value;
      logic               arg_valid;
   } req_item_type;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] top_value;
      logic [8:0]         stack_depth;
   } rsp_item_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic mem_read;
      logic load_req;
      logic commit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } sts_type;

endpackage

`default_nettype wire

[rtl/ispsa_ctrl.sv]
`default_nettype none

module ispsa_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_stall,
   input  ispsa_pkg::sts_type   sts,
   output ispsa_pkg::cmd_type   cmd
);

   ispsa_pkg::state_type state_ff;
   ispsa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ispsa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ispsa_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = ispsa_pkg::S_EXEC;
            end
         end
         ispsa_pkg::S_EXEC: begin
            if (!sts.rsp_busy) begin
               state_in = ispsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ispsa_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ispsa_pkg::S_IDLE: begin
            // prefetch the entry under the top while waiting
            req_stall    = reset;
            cmd.mem_read = 1'b1;
            cmd.load_req = req_valid && !reset;
         end
         ispsa_pkg::S_EXEC: begin
            cmd.commit = !sts.rsp_busy;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/ispsa_dp.sv]
`default_nettype none

module ispsa_dp #(
   parameter int STACK_DEPTH = ispsa_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire                       clock,
   input  wire                       reset,
   input  ispsa_pkg::req_item_type   req_item,
   input  wire                       rsp_stall,
   output logic                      rsp_valid,
   output ispsa_pkg::rsp_item_type   rsp_item,
   input  ispsa_pkg::cmd_type        cmd,
   output ispsa_pkg::sts_type        sts
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   // entries below the top; the top itself lives in top_ff
   logic [31:0] mem [STACK_DEPTH];

   ispsa_pkg::req_item_type req_ff;
   logic [CW-1:0]           cnt_ff;
   logic [CW-1:0]           cnt_in;
   logic [31:0]             top_ff;
   logic [31:0]             top_in;
   logic [31:0]             rd_ff;
   ispsa_pkg::rsp_item_type rsp_ff;
   ispsa_pkg::rsp_item_type rsp_in;
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;

   logic                    wr_en;
   logic [CW-1:0]           mem_idx;
   logic [CW-1:0]           rd_idx;
   logic [AW-1:0]           mem_addr;
   logic [CW-1:0]           cnt_nx;
   logic [31:0]             top_nx;
   ispsa_pkg::status_type   st_nx;
   logic [31:0]             cnt_wide;

   assign sts.rsp_busy = rsp_valid_ff && rsp_stall;
   assign rsp_valid    = rsp_valid_ff && !reset;
   assign rsp_item     = rsp_ff;

   // execute the held request against count, top and prefetched entry
   always_comb begin
      wr_en   = 1'b0;
      mem_idx = cnt_ff - CW'(2);
      cnt_nx  = cnt_ff;
      top_nx  = top_ff;
      st_nx   = ispsa_pkg::ST_OK;
      case (req_ff.req_type)
         ispsa_pkg::OP_PUSH: begin
            if (!req_ff.arg_valid) begin
               st_nx = ispsa_pkg::ST_PUSH_USAGE;
            end else if (cnt_ff == CW'(STACK_DEPTH)) begin
               st_nx = ispsa_pkg::ST_OVERFLOW;
            end else begin
               // spill the old top into memory
               wr_en   = (cnt_ff != '0);
               mem_idx = cnt_ff - CW'(1);
               top_nx  = req_ff.push_value;
               cnt_nx  = cnt_ff + CW'(1);
            end
         end
         ispsa_pkg::OP_POP: begin
            if (cnt_ff == '0) begin
               st_nx = ispsa_pkg::ST_POP_EMPTY;
            end else begin
               top_nx = rd_ff;
               cnt_nx = cnt_ff - CW'(1);
            end
         end
         ispsa_pkg::OP_SWAP: begin
            if (cnt_ff < CW'(2)) begin
               st_nx = ispsa_pkg::ST_SWAP_SHORT;
            end else begin
               wr_en  = 1'b1;
               top_nx = rd_ff;
            end
         end
         ispsa_pkg::OP_ADD: begin
            if (cnt_ff < CW'(2)) begin
               st_nx = ispsa_pkg::ST_ADD_SHORT;
            end else begin
               top_nx = rd_ff + top_ff;
               cnt_nx = cnt_ff - CW'(1);
            end
         end
         default: begin
            st_nx = ispsa_pkg::ST_OK;
         end
      endcase
   end

   // while idle, always fetch the entry just under the top
   assign rd_idx   = cnt_ff - CW'(2);
   assign mem_addr = cmd.mem_read ? rd_idx[AW-1:0] : mem_idx[AW-1:0];
   assign cnt_wide = 32'(cnt_nx);

   always_comb begin
      cnt_in       = cnt_ff;
      top_in       = top_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         cnt_in             = cnt_nx;
         top_in             = top_nx;
         rsp_in.status      = st_nx;
         rsp_in.top_value   = (cnt_nx != '0) ? top_nx : 32'sd0;
         rsp_in.stack_depth = cnt_wide[8:0];
         rsp_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
      rsp_ff <= rsp_in;
      if (cmd.load_req) begin
         req_ff <= req_item;
      end
   end

   // single port: reads happen only while idle, writes only on commit
   always_ff @(posedge clock) begin
      if (cmd.commit && wr_en) begin
         mem[mem_addr] <= top_ff;
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[mem_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/integer_stack_push_pop_swap_add.sv]
// Bounded stack of signed 32-bit integers: push, pop, swap, add.
// Request channel req_*: req_item carries the operation, the push operand
// and its valid flag; an item is taken when req_valid is high and
// req_stall is low. Result channel rsp_*: one item per request with the
// status, the new top (zero when empty) and the new depth.
// Timing: an item is taken in the idle state, executed in the execute state,
// and its result is registered into the output register when it commits.
// A new item is taken only after the last one commits; the single-port stack
// memory reads the entry under the top while idle and writes the spilled or
// swapped entry during execute.
// The top of stack is held in a register; the memory keeps the rest.
// Reset (synchronous, active high) empties the stack and drops any
// pending result; memory contents are not cleared and need no sweep.
// A stalled result holds in the output register; a finished request waits
// in execute until that register frees, and req_stall stays high meanwhile.
`default_nettype none

module integer_stack_push_pop_swap_add #(
   parameter int STACK_DEPTH = ispsa_pkg::DEFAULT_STACK_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  ispsa_pkg::req_item_type  req_item,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output ispsa_pkg::rsp_item_type  rsp_item
);

   ispsa_pkg::cmd_type cmd;
   ispsa_pkg::sts_type sts;

   // sequence the idle / execute handshake
   ispsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // hold count, top, stack memory and the result register
   ispsa_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

[rtl/ispsa_chk.sv]
`default_nettype none
`include "assert_macros.svh"

module ispsa_chk (
   input wire                      clock,
   input wire                      reset,
   input wire                      req_valid,
   input wire                      req_stall,
   input ispsa_pkg::req_item_type  req_item,
   input wire                      rsp_valid,
   input wire                      rsp_stall,
   input ispsa_pkg::rsp_item_type  rsp_item
);

   logic req_take;
   logic req_live;

   assign req_take = req_valid && !req_stall;
   assign req_live = req_take && (req_item.req_type == ispsa_pkg::OP_POP);

   // a stalled result holds
   `ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item))

   // no result right after reset
   `ASSERT_NXT_RST(a_rst_quiet, reset, !rsp_valid)

   // one request at a time: taking an item closes the request side
   `ASSERT_NXT(a_one_at_a_time, req_take || req_live, req_stall)

   // an empty pop reports an empty stack
   `ASSERT_IMP(a_pop_empty, rsp_valid && (rsp_item.status == ispsa_pkg::ST_POP_EMPTY),
      (rsp_item.stack_depth == 9'd0) && (rsp_item.top_value == 32'sd0))

endmodule

bind integer_stack_push_pop_swap_add ispsa_chk u_chk (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire
